// ===== src/imu_pkt_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser package
// Shared types, status codes, identifier table and record layout functions.
// ----------------------------------------------------------------------------
package imu_pkt_pkg;

   localparam int KNOWN_IDS    = 19;
   localparam int TABLE_SIZE   = 19;
   localparam int TABLE_SEARCH = (TABLE_SIZE < KNOWN_IDS) ? TABLE_SIZE : KNOWN_IDS;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [1:0] ST_VALUE   = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;

   localparam logic [2:0] K_REAL    = 3'd0;
   localparam logic [2:0] K_INT     = 3'd1;
   localparam logic [2:0] K_COUNTER = 3'd2;
   localparam logic [2:0] K_TIME    = 3'd3;
   localparam logic [2:0] K_STATUS  = 3'd4;

   localparam logic [15:0] ID_TABLE [KNOWN_IDS] = '{
      16'h0810, 16'h1010, 16'h1020, 16'h1060, 16'h1070, 16'h2010, 16'h2020,
      16'h2030, 16'h3010, 16'h4010, 16'h4020, 16'h4030, 16'h4040, 16'h8020,
      16'h8030, 16'h8040, 16'hE010, 16'hE020, 16'hC020
   };

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  record;
      logic [5:0]  vidx;
      logic [31:0] payload;
      logic        done;
   } q_entry_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] index;
   } lookup_type;

   function automatic lookup_type lookup_id(input logic [15:0] id);
      lookup_type res;
      res = '0;
      for (int i = TABLE_SEARCH - 1; i >= 0; i--) begin
         if (ID_TABLE[i] == id) begin
            res.hit   = 1'b1;
            res.index = 5'(i);
         end
      end
      return res;
   endfunction

   function automatic logic [2:0] kind_of(input logic [4:0] rec);
      logic [2:0] k;
      case (rec)
         5'd1:    k = K_TIME;
         5'd2:    k = K_COUNTER;
         5'd3:    k = K_INT;
         5'd4:    k = K_INT;
         5'd8:    k = K_INT;
         5'd16:   k = K_STATUS;
         5'd17:   k = K_INT;
         default: k = K_REAL;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] value_size(input logic [2:0] kind, input logic [6:0] n);
      logic [2:0] s;
      case (kind)
         K_REAL, K_INT: s = (n < 7'd63) ? 3'd4 : 3'd0;
         K_COUNTER:     s = (n < 7'd1) ? 3'd2 : 3'd0;
         K_STATUS:      s = (n < 7'd1) ? 3'd1 : 3'd0;
         K_TIME: begin
            if (n == 7'd0) s = 3'd4;
            else if (n == 7'd1) s = 3'd2;
            else if (n < 7'd7) s = 3'd1;
            else s = 3'd0;
         end
         default:       s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic value_fits(input logic [2:0] kind, input logic [6:0] n,
                                       input logic [7:0] left);
      logic [2:0] s;
      s = value_size(kind, n);
      return (s != 3'd0) && (left >= {5'd0, s});
   endfunction

endpackage

// ===== src/imu_data_packet_parser_top.sv =====
// ----------------------------------------------------------------------------
// IMU data packet parser
// Parses a sensor data message byte by byte and returns one result per
// completed value, unknown identifier or truncated record.
//
// The request channel takes one message byte per cycle with a flag that
// marks the final checksum byte. The csr channel writes the header skip
// count; it is always ready and should be written only while the parser is
// idle. The response channel returns one result at a time.
// A request is accepted every cycle while the four-entry result queue has
// room; its result passes through the queue into the response register.
// The parser state register loop sets the one byte per cycle rate. When
// the receiver stalls, the response register holds its result and the
// queue fills; once it is full, requests are held off.
// Reset returns the parser to the header phase, sets the header skip count
// to four and empties the queue.
// ----------------------------------------------------------------------------
module imu_data_packet_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_record_index,
   output logic [5:0]  rsp_value_index,
   output logic [31:0] rsp_value_word,
   output logic        rsp_value_is_real,
   output logic        rsp_record_done,
   output logic [15:0] rsp_unknown_id
);

   logic                      queue_full;
   logic                      push_valid;
   imu_pkt_pkg::q_entry_type  push_entry;
   logic                      pop;
   logic                      head_valid;
   imu_pkt_pkg::q_entry_type  head_entry;

   imu_pkt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   imu_pkt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   imu_pkt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_record_index  (rsp_record_index),
      .rsp_value_index   (rsp_value_index),
      .rsp_value_word    (rsp_value_word),
      .rsp_value_is_real (rsp_value_is_real),
      .rsp_record_done   (rsp_record_done),
      .rsp_unknown_id    (rsp_unknown_id)
   );

endmodule

// ===== src/imu_pkt_front.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser front end
// Accepts message bytes, tracks the record structure and queues one result
// entry for every completed value, unknown identifier or truncated record.
// ----------------------------------------------------------------------------
module imu_pkt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_data,
   input  logic                      queue_full,
   output logic                      push_valid,
   output imu_pkt_pkg::q_entry_type  push_entry
);

   typedef enum logic [6:0] {
      PH_HEADER  = 7'b0000001,
      PH_ID_HI   = 7'b0000010,
      PH_ID_LO   = 7'b0000100,
      PH_LEN     = 7'b0001000,
      PH_BODY    = 7'b0010000,
      PH_EXCESS  = 7'b0100000,
      PH_UNKNOWN = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  skip_ff, skip_in;
   logic [7:0]  hcount_ff, hcount_in;
   logic [7:0]  id_high_ff, id_high_in;
   logic [4:0]  record_ff, record_in;
   logic [7:0]  left_ff, left_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  biv_ff, biv_in;
   logic [5:0]  vcount_ff, vcount_in;

   logic                     accept;
   logic [2:0]               kind;
   logic [7:0]               left_dec;
   logic [2:0]               biv_inc;
   logic [31:0]              shift_next;
   logic                     more;
   imu_pkt_pkg::lookup_type  hit;

   assign req_ready  = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_valid && req_ready;
   assign kind       = imu_pkt_pkg::kind_of(record_ff);
   assign left_dec   = left_ff - 8'd1;
   assign biv_inc    = biv_ff + 3'd1;
   assign shift_next = {shift_ff[23:0], req_data_byte};
   assign more       = imu_pkt_pkg::value_fits(kind, {1'b0, vcount_ff} + 7'd1, left_dec);
   assign hit        = imu_pkt_pkg::lookup_id({id_high_ff, req_data_byte});

   always_comb begin
      phase_in   = phase_ff;
      skip_in    = (csr_valid && csr_ready) ? csr_data : skip_ff;
      hcount_in  = hcount_ff;
      id_high_in = id_high_ff;
      record_in  = record_ff;
      left_in    = left_ff;
      shift_in   = shift_ff;
      biv_in     = biv_ff;
      vcount_in  = vcount_ff;
      push_valid = 1'b0;
      push_entry = '0;
      if (accept) begin
         if (req_last_byte) begin
            if (phase_ff == PH_ID_LO) begin
               push_valid        = 1'b1;
               push_entry.status = imu_pkt_pkg::ST_TRUNC;
            end else if (phase_ff == PH_LEN ||
                         ((phase_ff == PH_BODY || phase_ff == PH_EXCESS) && left_ff != 8'd0)) begin
               push_valid        = 1'b1;
               push_entry.status = imu_pkt_pkg::ST_TRUNC;
               push_entry.record = record_ff;
               push_entry.vidx   = vcount_ff;
            end
            phase_in   = PH_HEADER;
            hcount_in  = '0;
            id_high_in = '0;
            record_in  = '0;
            left_in    = '0;
            shift_in   = '0;
            biv_in     = '0;
            vcount_in  = '0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (hcount_ff < skip_ff) begin
                     hcount_in = hcount_ff + 8'd1;
                  end else begin
                     id_high_in = req_data_byte;
                     phase_in   = PH_ID_LO;
                  end
               end
               PH_ID_HI: begin
                  id_high_in = req_data_byte;
                  phase_in   = PH_ID_LO;
               end
               PH_ID_LO: begin
                  if (hit.hit) begin
                     record_in = hit.index;
                     phase_in  = PH_LEN;
                  end else begin
                     push_valid         = 1'b1;
                     push_entry.status  = imu_pkt_pkg::ST_UNKNOWN;
                     push_entry.payload = {16'd0, id_high_ff, req_data_byte};
                     phase_in           = PH_UNKNOWN;
                  end
               end
               PH_LEN: begin
                  left_in   = req_data_byte;
                  shift_in  = '0;
                  biv_in    = '0;
                  vcount_in = '0;
                  if (req_data_byte == 8'd0) begin
                     phase_in = PH_ID_HI;
                  end else if (imu_pkt_pkg::value_fits(kind, 7'd0, req_data_byte)) begin
                     phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_EXCESS;
                  end
               end
               PH_BODY: begin
                  left_in  = left_dec;
                  shift_in = shift_next;
                  biv_in   = biv_inc;
                  if (biv_inc >= imu_pkt_pkg::value_size(kind, {1'b0, vcount_ff})) begin
                     push_valid         = 1'b1;
                     push_entry.status  = imu_pkt_pkg::ST_VALUE;
                     push_entry.record  = record_ff;
                     push_entry.vidx    = vcount_ff;
                     push_entry.payload = shift_next;
                     push_entry.done    = !more;
                     vcount_in          = vcount_ff + 6'd1;
                     shift_in           = '0;
                     biv_in             = '0;
                     if (left_dec == 8'd0) begin
                        phase_in = PH_ID_HI;
                     end else if (!more) begin
                        phase_in = PH_EXCESS;
                     end
                  end
               end
               PH_EXCESS: begin
                  if (left_ff != 8'd0) begin
                     left_in = left_dec;
                  end
                  if (left_ff <= 8'd1) begin
                     phase_in = PH_ID_HI;
                  end
               end
               PH_UNKNOWN: begin
                  phase_in = PH_UNKNOWN;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         skip_ff    <= 8'd4;
         hcount_ff  <= '0;
         id_high_ff <= '0;
         record_ff  <= '0;
         left_ff    <= '0;
         shift_ff   <= '0;
         biv_ff     <= '0;
         vcount_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         hcount_ff  <= hcount_in;
         id_high_ff <= id_high_in;
         record_ff  <= record_in;
         left_ff    <= left_in;
         shift_ff   <= shift_in;
         biv_ff     <= biv_in;
         vcount_ff  <= vcount_in;
      end
   end

endmodule

// ===== src/imu_pkt_fifo.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser result queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imu_pkt_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  imu_pkt_pkg::q_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output imu_pkt_pkg::q_entry_type  head_entry
);

   imu_pkt_pkg::q_entry_type               mem_ff [imu_pkt_pkg::QDEPTH];
   logic [imu_pkt_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [imu_pkt_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [imu_pkt_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign full       = (count_ff == imu_pkt_pkg::QCNT_W'(imu_pkt_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/imu_pkt_back.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser back end
// Takes queued entries, expands them into result fields and holds them in
// the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module imu_pkt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  imu_pkt_pkg::q_entry_type  head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [4:0]                rsp_record_index,
   output logic [5:0]                rsp_value_index,
   output logic [31:0]               rsp_value_word,
   output logic                      rsp_value_is_real,
   output logic                      rsp_record_done,
   output logic [15:0]               rsp_unknown_id
);

   logic        valid_ff, valid_in;
   logic [1:0]  status_ff;
   logic [4:0]  record_ff;
   logic [5:0]  vidx_ff;
   logic [31:0] word_ff;
   logic        real_ff;
   logic        done_ff;
   logic [15:0] uid_ff;
   logic        is_value;

   assign pop      = head_valid && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);
   assign is_value = (head_entry.status == imu_pkt_pkg::ST_VALUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= head_entry.status;
         record_ff <= head_entry.record;
         vidx_ff   <= head_entry.vidx;
         word_ff   <= is_value ? head_entry.payload : 32'd0;
         real_ff   <= is_value &&
                      (imu_pkt_pkg::kind_of(head_entry.record) == imu_pkt_pkg::K_REAL);
         done_ff   <= is_value && head_entry.done;
         uid_ff    <= (head_entry.status == imu_pkt_pkg::ST_UNKNOWN) ?
                      head_entry.payload[15:0] : 16'd0;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_record_index  = record_ff;
   assign rsp_value_index   = vidx_ff;
   assign rsp_value_word    = word_ff;
   assign rsp_value_is_real = real_ff;
   assign rsp_record_done   = done_ff;
   assign rsp_unknown_id    = uid_ff;

endmodule

// ===== src/imu_pkt_checker.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module imu_pkt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_record_index,
   input logic [5:0]  rsp_value_index,
   input logic [31:0] rsp_value_word,
   input logic        rsp_value_is_real,
   input logic        rsp_record_done,
   input logic [15:0] rsp_unknown_id
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_word) &&
                                  $stable(rsp_status) && $stable(rsp_value_index))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("parser not empty and ready right after reset");

   a_unknown_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == imu_pkt_pkg::ST_UNKNOWN |->
         rsp_value_word == 32'd0 && !rsp_record_done && !rsp_value_is_real &&
         rsp_record_index == 5'd0)
      else $error("unknown identifier result carries value fields");

   a_value_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == imu_pkt_pkg::ST_VALUE |->
         rsp_unknown_id == 16'd0 && rsp_record_index < 5'(imu_pkt_pkg::KNOWN_IDS))
      else $error("value result has bad identifier fields");

   a_trunc_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == imu_pkt_pkg::ST_TRUNC |->
         rsp_value_word == 32'd0 && !rsp_record_done && rsp_unknown_id == 16'd0)
      else $error("truncation result carries value fields");

endmodule

bind imu_data_packet_parser_top imu_pkt_checker u_imu_pkt_checker (.*);

// ===== test/imu_data_packet_parser_checker.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser checker
// Watches the request, csr and response channels of the parser. Every accepted
// request byte is run through a local model of the message parser, and the
// values, unknown identifiers and truncated records it predicts are queued.
// Every accepted response is compared field by field with the oldest queued
// prediction; mismatches and unexpected responses are reported and counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module imu_data_packet_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [4:0]  rsp_record_index,
   input  logic [5:0]  rsp_value_index,
   input  logic [31:0] rsp_value_word,
   input  logic        rsp_value_is_real,
   input  logic        rsp_record_done,
   input  logic [15:0] rsp_unknown_id,
   output int          mismatches,
   output int          outstanding,
   output int          n_values,
   output int          n_unknown,
   output int          n_trunc
);

   typedef enum logic [6:0] {
      P_HEADER  = 7'b0000001,
      P_ID_HI   = 7'b0000010,
      P_ID_LO   = 7'b0000100,
      P_LEN     = 7'b0001000,
      P_BODY    = 7'b0010000,
      P_EXCESS  = 7'b0100000,
      P_UNKNOWN = 7'b1000000
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  rec;
      logic [5:0]  vidx;
      logic [31:0] word;
      logic        is_float;
      logic        done;
      logic [15:0] uid;
   } parse_result_type;

   localparam logic [2:0] RECORD_KIND [imu_pkt_pkg::KNOWN_IDS] = '{
      imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_TIME, imu_pkt_pkg::K_COUNTER,
      imu_pkt_pkg::K_INT, imu_pkt_pkg::K_INT, imu_pkt_pkg::K_REAL,
      imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_INT,
      imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_REAL,
      imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_REAL,
      imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_STATUS, imu_pkt_pkg::K_INT,
      imu_pkt_pkg::K_REAL
   };

   logic [7:0]       skip_bytes;
   parse_phase_type  ph;
   logic [7:0]       hdr_seen;
   logic [7:0]       id_msb;
   logic [4:0]       rec;
   logic [7:0]       left;
   logic [31:0]      acc;
   logic [2:0]       acc_bytes;
   logic [5:0]       nvals;
   parse_result_type parse_results[$];
   int               n_bad = 0;
   int               n_val = 0;
   int               n_unk = 0;
   int               n_trc = 0;

   function automatic logic [2:0] value_bytes(input logic [4:0] r, input logic [6:0] n);
      logic [2:0] sz;
      case (RECORD_KIND[r])
         imu_pkt_pkg::K_REAL, imu_pkt_pkg::K_INT: sz = (n < 7'd63) ? 3'd4 : 3'd0;
         imu_pkt_pkg::K_COUNTER: sz = (n == 7'd0) ? 3'd2 : 3'd0;
         imu_pkt_pkg::K_STATUS:  sz = (n == 7'd0) ? 3'd1 : 3'd0;
         imu_pkt_pkg::K_TIME:    sz = (n == 7'd0) ? 3'd4 : (n == 7'd1) ? 3'd2 :
                                      (n < 7'd7) ? 3'd1 : 3'd0;
         default:                sz = 3'd0;
      endcase
      return sz;
   endfunction

   function automatic logic value_room(input logic [4:0] r, input logic [6:0] n,
                                       input logic [7:0] lft);
      logic [2:0] sz;
      sz = value_bytes(r, n);
      return (sz != 3'd0) && (lft >= {5'd0, sz});
   endfunction

   function automatic parse_result_type make_result(
      input logic [1:0] st, input logic [4:0] r, input logic [5:0] vi,
      input logic [31:0] w, input logic fl, input logic dn, input logic [15:0] uid);
      parse_result_type res;
      res.status   = st;
      res.rec      = r;
      res.vidx     = vi;
      res.word     = w;
      res.is_float = fl;
      res.done     = dn;
      res.uid      = uid;
      return res;
   endfunction

   task automatic restart_message();
      ph        = P_HEADER;
      hdr_seen  = '0;
      id_msb    = '0;
      rec       = '0;
      left      = '0;
      acc       = '0;
      acc_bytes = '0;
      nvals     = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic last);
      logic [15:0] id;
      logic        hit;
      logic [4:0]  idx;
      logic        more;
      if (last) begin
         if (ph == P_ID_LO) begin
            parse_results.push_back(make_result(imu_pkt_pkg::ST_TRUNC, '0, '0, '0,
                                                1'b0, 1'b0, '0));
         end else if (ph == P_LEN || ((ph == P_BODY || ph == P_EXCESS) && left != 0)) begin
            parse_results.push_back(make_result(imu_pkt_pkg::ST_TRUNC, rec, nvals, '0,
                                                1'b0, 1'b0, '0));
         end
         restart_message();
         return;
      end
      if (ph == P_HEADER) begin
         if (hdr_seen < skip_bytes) begin
            hdr_seen = hdr_seen + 8'd1;
            return;
         end
         ph = P_ID_HI;
      end
      case (ph)
         P_ID_HI: begin
            id_msb = b;
            ph = P_ID_LO;
         end
         P_ID_LO: begin
            id  = {id_msb, b};
            hit = 1'b0;
            idx = '0;
            for (int i = 0; i < imu_pkt_pkg::KNOWN_IDS && i < imu_pkt_pkg::TABLE_SIZE;
                 i++) begin
               if (!hit && imu_pkt_pkg::ID_TABLE[i] == id) begin
                  hit = 1'b1;
                  idx = 5'(i);
               end
            end
            if (hit) begin
               rec = idx;
               ph = P_LEN;
            end else begin
               parse_results.push_back(make_result(imu_pkt_pkg::ST_UNKNOWN, '0, '0, '0,
                                                   1'b0, 1'b0, id));
               ph = P_UNKNOWN;
            end
         end
         P_LEN: begin
            left      = b;
            acc       = '0;
            acc_bytes = '0;
            nvals     = '0;
            if (left == 0) ph = P_ID_HI;
            else ph = value_room(rec, 7'd0, left) ? P_BODY : P_EXCESS;
         end
         P_BODY: begin
            left      = left - 8'd1;
            acc       = {acc[23:0], b};
            acc_bytes = acc_bytes + 3'd1;
            if (acc_bytes >= value_bytes(rec, {1'b0, nvals})) begin
               more = value_room(rec, {1'b0, nvals} + 7'd1, left);
               parse_results.push_back(make_result(imu_pkt_pkg::ST_VALUE, rec, nvals, acc,
                                                   RECORD_KIND[rec] == imu_pkt_pkg::K_REAL,
                                                   !more, '0));
               nvals     = nvals + 6'd1;
               acc       = '0;
               acc_bytes = '0;
               if (left == 0) ph = P_ID_HI;
               else if (!more) ph = P_EXCESS;
            end
         end
         P_EXCESS: begin
            if (left != 0) left = left - 8'd1;
            if (left == 0) ph = P_ID_HI;
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      n_bad++;
   endtask

   task automatic check_response();
      parse_result_type got;
      parse_result_type want;
      got = make_result(rsp_status, rsp_record_index, rsp_value_index, rsp_value_word,
                        rsp_value_is_real, rsp_record_done, rsp_unknown_id);
      if (parse_results.size() == 0) begin
         report("response with no prediction pending, status", 32'(got.status), '0);
         return;
      end
      want = parse_results.pop_front();
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.rec !== want.rec) report("record_index", 32'(got.rec), 32'(want.rec));
      if (got.vidx !== want.vidx) report("value_index", 32'(got.vidx), 32'(want.vidx));
      if (got.word !== want.word) report("value_word", got.word, want.word);
      if (got.is_float !== want.is_float) begin
         report("value_is_real", 32'(got.is_float), 32'(want.is_float));
      end
      if (got.done !== want.done) report("record_done", 32'(got.done), 32'(want.done));
      if (got.uid !== want.uid) report("unknown_id", 32'(got.uid), 32'(want.uid));
      case (want.status)
         imu_pkt_pkg::ST_VALUE:   n_val++;
         imu_pkt_pkg::ST_UNKNOWN: n_unk++;
         default:                 n_trc++;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         skip_bytes = 8'd4;
         restart_message();
         parse_results.delete();
      end else begin
         if (csr_valid && csr_ready) skip_bytes = csr_data;
         if (req_valid && req_ready) parse_byte(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) check_response();
      end
      mismatches  <= n_bad;
      outstanding <= parse_results.size();
      n_values    <= n_val;
      n_unknown   <= n_unk;
      n_trunc     <= n_trc;
   end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// IMU packet parser testbench
// Feeds sensor data messages to the parser one byte per request: a short
// directed sequence, then random messages built from known and unknown
// records with random lengths, truncated messages and noise. The header skip
// count is changed between phases, sender and receiver stall at random, and a
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int LONG_HOLD   = 60;
   localparam int DRAIN       = 8;
   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        csr_valid = 1'b0;
   logic [7:0]  csr_data = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        csr_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_record_index;
   logic [5:0]  rsp_value_index;
   logic [31:0] rsp_value_word;
   logic        rsp_value_is_real;
   logic        rsp_record_done;
   logic [15:0] rsp_unknown_id;

   int          mismatches;
   int          outstanding;
   int          n_values;
   int          n_unknown;
   int          n_trunc;

   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          hold_asked = 0;
   int          hold_given = 0;
   int          stall_left = 0;
   int          quiet = 0;
   int          n_sent = 0;
   logic [7:0]  cur_skip = 8'd4;

   imu_data_packet_parser_top u_top (.*);

   imu_data_packet_parser_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_ready  <= 1'b0;
         stall_left <= LONG_HOLD;
         hold_given <= hold_given + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_skip(input logic [7:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_skip = v;
   endtask

   task automatic send_message();
      logic [7:0]  msg[$];
      logic [15:0] id;
      int          len;
      int          cut;
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(1, 12)) begin
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
         end
         return;
      end
      repeat (cur_skip) msg.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(99) < 8) begin
            id  = 16'($urandom);
            len = $urandom_range(0, 6);
         end else begin
            id = imu_pkt_pkg::ID_TABLE[$urandom_range(imu_pkt_pkg::KNOWN_IDS - 1)];
            case ($urandom_range(9))
               0:       len = $urandom_range(0, 3);
               1:       len = 2;
               2:       len = 1;
               3:       len = 11;
               9:       len = $urandom_range(5, 24);
               default: len = 4 * $urandom_range(1, 4);
            endcase
            if ($urandom_range(199) == 0) len = $urandom_range(240, 255);
         end
         msg.push_back(id[15:8]);
         msg.push_back(id[7:0]);
         msg.push_back(8'(len));
         repeat (len) msg.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(msg.size());
         while (msg.size() > cut) void'(msg.pop_back());
      end
      foreach (msg[i]) send_byte(msg[i], 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic run_phase(input int budget);
      int start;
      start = n_sent;
      while (n_sent - start < budget) send_message();
   endtask

   initial begin
      tx_idle_pct = 21;
      rx_idle_pct <= 70;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Default header skip of four, then a counter record and a status record.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(imu_pkt_pkg::ID_TABLE[2][15:8], 1'b0);
      send_byte(imu_pkt_pkg::ID_TABLE[2][7:0], 1'b0);
      send_byte(8'd2, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(imu_pkt_pkg::ID_TABLE[16][15:8], 1'b0);
      send_byte(imu_pkt_pkg::ID_TABLE[16][7:0], 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b1);

      // Header skip drops to zero while two header bytes are already in.
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      write_skip(8'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(imu_pkt_pkg::ID_TABLE[0][15:8], 1'b0);
      send_byte(8'h11, 1'b1);
      send_byte(imu_pkt_pkg::ID_TABLE[0][15:8], 1'b0);
      send_byte(imu_pkt_pkg::ID_TABLE[0][7:0], 1'b0);
      send_byte(8'hEE, 1'b1);

      write_skip(8'd2);
      run_phase(300);
      write_skip(8'd255);
      run_phase(250);

      tx_idle_pct = 70;
      rx_idle_pct <= 21;
      write_skip(8'd0);
      hold_asked <= hold_asked + 1;
      run_phase(250);
      wait_drained();
      run_phase(200);

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      write_skip(8'($urandom_range(1, 8)));
      hold_asked <= hold_asked + 1;
      run_phase(300);
      write_skip(8'd4);
      run_phase(300);

      wait_drained();
      $display("Sent %0d request bytes over header skips 0, 2, 4, 255 and a random one,",
               n_sent);
      $display("with random and long stalls; checked %0d values, %0d unknown ids,",
               n_values, n_unknown);
      $display("and %0d cut records.", n_trunc);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== imu_data_packet_parser_top.f =====
src/imu_pkt_pkg.sv
src/imu_pkt_front.sv
src/imu_pkt_fifo.sv
src/imu_pkt_back.sv
src/imu_data_packet_parser_top.sv
src/imu_pkt_checker.sv
test/imu_data_packet_parser_checker.sv
test/testbench.sv
